>>> hw/rtl/rtp_pkg.sv
`timescale 1ns / 1ps

package rtp_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int GUARD_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  // datapath: input << GUARD_BITS plus headroom for the CORDIC gain and pi pre-rotation
  localparam int XY_WIDTH   = DATA_WIDTH + GUARD_BITS + 4;
  localparam int Z_WIDTH    = 36;
  localparam int GAIN_WIDTH = 32;
  localparam int MULT_WIDTH = (XY_WIDTH - 1) + GAIN_WIDTH;
  localparam int MAG_SHIFT  = 48;
  localparam int MAG_FULL_W = MULT_WIDTH - MAG_SHIFT;
  localparam int PH_SHIFT   = 17;
  localparam int PH_FULL_W  = Z_WIDTH + 1 - PH_SHIFT;

  localparam logic [GAIN_WIDTH-1:0]     GAIN_Q32  = 32'd2608131496;
  localparam logic signed [Z_WIDTH-1:0] PI_Q30    = 36'sd3373259426;
  localparam logic [DATA_WIDTH-1:0]     MAG_MAX   = 16'd46341;
  localparam logic signed [DATA_WIDTH-1:0] PHASE_MAX = 16'sd25736;

  typedef struct packed {
    logic signed [XY_WIDTH-1:0] x;
    logic signed [XY_WIDTH-1:0] y;
    logic signed [Z_WIDTH-1:0]  z;
    logic                       zero;
  } rtp_vec_t;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [Z_WIDTH-1:0] atan_angle(input int i);
    logic [63:0] a;
    unique case (i)
      0:       a = 64'd843314857;
      1:       a = 64'd497837829;
      2:       a = 64'd263043837;
      3:       a = 64'd133525159;
      4:       a = 64'd67021687;
      5:       a = 64'd33543516;
      6:       a = 64'd16775851;
      7:       a = 64'd8388437;
      8:       a = 64'd4194283;
      9:       a = 64'd2097149;
      default: a = (64'd1 << 30) >> i;
    endcase
    return Z_WIDTH'(a);
  endfunction

endpackage

>>> hw/rtl/rect_to_polar_converter_core.sv
`timescale 1ns / 1ps

// Channel    Dir  Width  Contents (low bit first)
// s_axis     in   32     real_part[15:0], imag_part[15:0]
// m_axis     out  32     magnitude[15:0], phase[15:0]
// phase_en   in   1      write enable + data for phase_enable
//
// One request per cycle sustained while the output is not stalled; stages in order: 1 pre-rotation stage,
// 16 CORDIC micro-rotation stages, gain multiply stage, round/clamp output stage.
// Each stage has its own valid bit; a stage loads whenever it is empty or its
// content moves on, so bubbles collapse under a stalled output.
// rst (synchronous) clears all valid bits and sets phase_enable to 1.
// s_axis_tready depends combinationally on m_axis_tready through the valid chain.

module rect_to_polar_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        phase_enable_wr_en,
  input  logic        phase_enable_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // real_part[15:0], imag_part[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // magnitude[15:0], phase[31:16]
);
  import rtp_pkg::*;

  logic phase_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_enable <= 1'b1;
    end else if (phase_enable_wr_en) begin
      phase_enable <= phase_enable_wr_data;
    end
  end

  logic                         cv_valid, cv_ready;
  rtp_vec_t                     cv_vec;
  logic [DATA_WIDTH-1:0]        magnitude;
  logic signed [DATA_WIDTH-1:0] phase;

  rtp_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .re        (s_axis_tdata[DATA_WIDTH-1:0]),
    .im        (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_valid (cv_valid),
    .out_ready (cv_ready),
    .out_vec   (cv_vec)
  );

  rtp_post u_post (
    .clk          (clk),
    .rst          (rst),
    .phase_enable (phase_enable),
    .in_valid     (cv_valid),
    .in_ready     (cv_ready),
    .in_vec       (cv_vec),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .magnitude    (magnitude),
    .phase        (phase)
  );

  assign m_axis_tdata = {phase, magnitude};

  // a drained output never back-pressures the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with output draining");

  // empty pipeline after reset takes input
  a_reset_ready: assert property (@(posedge clk)
    rst |=> (s_axis_tready && !m_axis_tvalid))
    else $error("pipeline not empty after reset");

endmodule

>>> hw/rtl/rtp_cordic.sv
`timescale 1ns / 1ps

module rtp_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rtp_pkg::DATA_WIDTH-1:0] re,
  input  logic signed [rtp_pkg::DATA_WIDTH-1:0] im,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rtp_pkg::rtp_vec_t                     out_vec
);
  import rtp_pkg::*;

  localparam int NS = CORDIC_STAGES + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  rtp_vec_t      vec [NS];

  // stage can load when empty or when its content moves on
  assign rdy[NS-1] = ~vld[NS-1] | out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = ~vld[k] | rdy[k+1];
  end

  // stage 0: scale, fold left half-plane by pi
  logic signed [XY_WIDTH-1:0] xs, ys;
  rtp_vec_t                   pre;

  always_comb begin
    xs       = XY_WIDTH'(re) <<< GUARD_BITS;
    ys       = XY_WIDTH'(im) <<< GUARD_BITS;
    pre.zero = (re == '0) && (im == '0);
    if (xs < 0) begin
      pre.x = -xs;
      pre.y = -ys;
      pre.z = (ys >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      pre.x = xs;
      pre.y = ys;
      pre.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      vec[0] <= pre;
    end
  end

  // one micro-rotation per stage
  for (genvar k = 1; k < NS; k++) begin : g_stage
    localparam int I = k - 1;
    logic signed [XY_WIDTH-1:0] xi, yi, dx, dy;
    logic signed [Z_WIDTH-1:0]  zi;
    rtp_vec_t                   nxt;

    always_comb begin
      xi       = vec[k-1].x;
      yi       = vec[k-1].y;
      zi       = vec[k-1].z;
      dx       = yi >>> I;
      dy       = xi >>> I;
      nxt.zero = vec[k-1].zero;
      if (yi >= 0) begin
        nxt.x = xi + dx;
        nxt.y = yi - dy;
        nxt.z = zi + atan_angle(I);
      end else begin
        nxt.x = xi - dx;
        nxt.y = yi + dy;
        nxt.z = zi - atan_angle(I);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld[k-1]) begin
        vec[k] <= nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];
  assign out_vec   = vec[NS-1];

endmodule

>>> hw/rtl/rtp_post.sv
`timescale 1ns / 1ps

module rtp_post (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  phase_enable,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rtp_pkg::rtp_vec_t                     in_vec,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [rtp_pkg::DATA_WIDTH-1:0] magnitude,
  output logic signed [rtp_pkg::DATA_WIDTH-1:0] phase
);
  import rtp_pkg::*;

  // stage A: gain multiply, phase round and clamp
  logic                           va, vb, ra, rb;
  logic [MULT_WIDTH-1:0]          prod;
  logic signed [DATA_WIDTH-1:0]   ph_a;
  logic                           zero_a;

  logic [XY_WIDTH-2:0]            xpos;
  logic signed [Z_WIDTH:0]        zr;
  logic signed [PH_FULL_W-1:0]    ph_full;
  logic signed [DATA_WIDTH-1:0]   ph_clip;

  assign rb = ~vb | out_ready;
  assign ra = ~va | rb;

  always_comb begin
    xpos    = in_vec.x[XY_WIDTH-1] ? '0 : in_vec.x[XY_WIDTH-2:0];
    zr      = (Z_WIDTH+1)'(in_vec.z) + (Z_WIDTH+1)'(65536);
    ph_full = PH_FULL_W'(zr >>> PH_SHIFT);
    if (ph_full > PH_FULL_W'(PHASE_MAX)) begin
      ph_clip = PHASE_MAX;
    end else if (ph_full < -PH_FULL_W'(PHASE_MAX)) begin
      ph_clip = -PHASE_MAX;
    end else begin
      ph_clip = DATA_WIDTH'(ph_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && in_valid) begin
      prod   <= MULT_WIDTH'(xpos) * MULT_WIDTH'(GAIN_Q32);
      ph_a   <= ph_clip;
      zero_a <= in_vec.zero;
    end
  end

  // stage B: magnitude round and clamp, overrides, output register
  logic [MULT_WIDTH-1:0] rsum;
  logic [MAG_FULL_W-1:0] mag_full;
  logic [DATA_WIDTH-1:0] mag_clip;

  always_comb begin
    rsum     = prod + (MULT_WIDTH'(1) << (MAG_SHIFT - 1));
    mag_full = rsum[MULT_WIDTH-1:MAG_SHIFT];
    mag_clip = (mag_full > MAG_FULL_W'(MAG_MAX)) ? MAG_MAX : DATA_WIDTH'(mag_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rb) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rb && va) begin
      magnitude <= zero_a ? '0 : mag_clip;
      phase     <= (zero_a || !phase_enable) ? '0 : ph_a;
    end
  end

  assign in_ready  = ra;
  assign out_valid = vb;

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= MAG_MAX)
    else $error("magnitude above clamp");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phase <= PHASE_MAX && phase >= -PHASE_MAX))
    else $error("phase out of range");

  a_phase_off: assert property (@(posedge clk) disable iff (rst)
    (rb && va && !phase_enable) |=> phase == '0)
    else $error("phase not forced to zero");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import rtp_pkg::*;

  localparam int LIMIT        = 400000;
  localparam int DRAIN_CYCLES = 30;   // pipeline is 19 deep

  // packed so that the last field sits in the low bits of tdata
  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] phase;
    logic [15:0]        mag;
  } polar_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        phase_enable_wr_en   = 1'b0;
  logic        phase_enable_wr_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  sample_t pending[$];          // requests waiting to be driven
  polar_t  polar_expected[$];   // predicted results, oldest first
  sample_t head;
  polar_t  got, want;
  bit      phase_on = 1'b1;     // mirror of phase_enable
  bit      calm = 1'b0;         // stretch with no idling on either side
  bit      in_taken = 1'b0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      n_accepted = 0;
  int      n_checked = 0;
  int      errors = 0;
  int      cycle_cnt = 0;

  rect_to_polar_converter_core i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .phase_enable_wr_en   (phase_enable_wr_en),
    .phase_enable_wr_data (phase_enable_wr_data),
    .s_axis_tvalid        (s_axis_tvalid),
    .s_axis_tready        (s_axis_tready),
    .s_axis_tdata         (s_axis_tdata),
    .m_axis_tvalid        (m_axis_tvalid),
    .m_axis_tready        (m_axis_tready),
    .m_axis_tdata         (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Vectoring CORDIC with pi pre-rotation, 16 guard bits, angles in 2^-30 rad.
  function automatic polar_t to_polar(sample_t s, bit with_phase);
    longint x, y, z, dx, dy, step, ph;
    logic [63:0] prod;
    polar_t r;
    int i;
    r = '0;
    if (s.re == 0 && s.im == 0) return r;
    x = longint'(s.re) * 65536;
    y = longint'(s.im) * 65536;
    z = 0;
    // left half-plane: flip and start at +-pi; imag 0 there lands on +pi
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      case (i)
        0:       step = 843314857;
        1:       step = 497837829;
        2:       step = 263043837;
        3:       step = 133525159;
        4:       step = 67021687;
        5:       step = 33543516;
        6:       step = 16775851;
        7:       step = 8388437;
        8:       step = 4194283;
        9:       step = 2097149;
        default: step = (longint'(1) << 30) >>> i;
      endcase
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += step;
      end else begin
        x -= dx;
        y += dy;
        z -= step;
      end
    end
    if (x < 0) x = 0;
    prod = $unsigned(x) * 64'(GAIN_Q32) + (64'd1 << 47);
    r.mag = ((prod >> 48) > MAG_MAX) ? MAG_MAX : 16'(prod >> 48);
    ph = (z + 65536) >>> 17;
    if (ph > longint'(PHASE_MAX)) ph = PHASE_MAX;
    if (ph < -longint'(PHASE_MAX)) ph = -longint'(PHASE_MAX);
    r.phase = with_phase ? 16'(ph) : 16'sd0;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mix of full-range, near-zero, on-axis and extreme values
  function automatic logic signed [15:0] pick_field();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = 16'($urandom_range(0, 8)) - 16'sd4;
      2:    v = 16'sd0;
      3: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h8000;
          1:       v = 16'h7fff;
          2:       v = 16'hffff;
          default: v = 16'h8001;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_sample(int re, int im);
    sample_t s;
    s.re = 16'(re);
    s.im = 16'(im);
    pending.push_back(s);
  endtask

  task automatic queue_random(int n);
    sample_t s;
    repeat (n) begin
      s.re = pick_field();
      s.im = pick_field();
      pending.push_back(s);
    end
  endtask

  // back to idle: everything driven and every result checked
  task automatic settle();
    do @(posedge clk);
    while (pending.size() != 0 || s_axis_tvalid || n_checked != n_accepted);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase_enable(bit v);
    @(negedge clk);
    phase_enable_wr_en   <= 1'b1;
    phase_enable_wr_data <= v;
    @(negedge clk);
    phase_enable_wr_en   <= 1'b0;
    phase_on = v;
    @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        head = pending.pop_front();
        s_axis_tdata  <= head;
        s_axis_tvalid <= 1'b1;
        gap_left = idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = idle_len();
    end
  end

  // accepted requests -> predicted results
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        polar_expected.push_back(to_polar(sample_t'(s_axis_tdata), phase_on));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = polar_t'(m_axis_tdata);
      if (polar_expected.size() == 0) begin
        $error("unexpected result: magnitude %0d phase %0d", got.mag, got.phase);
        errors++;
      end else begin
        want = polar_expected.pop_front();
        if (got.mag !== want.mag) begin
          $error("magnitude: expected %0d, got %0d", want.mag, got.mag);
          errors++;
        end
        if (got.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          errors++;
        end
      end
      n_checked <= n_checked + 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    // phase on (reset value): corners, axes, unit steps
    queue_sample(0, 0);
    queue_sample(32767, 0);
    queue_sample(-32768, 0);
    queue_sample(0, 32767);
    queue_sample(0, -32768);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    queue_sample(1, 0);
    queue_sample(-1, 0);
    queue_sample(0, 1);
    queue_sample(0, -1);
    queue_sample(-1, -1);
    queue_sample(1, 1);
    queue_sample(-12345, 0);
    queue_sample(3, -4);
    queue_sample(-30000, 1);
    queue_sample(-30000, -1);
    queue_sample(20000, -15000);
    queue_random(500);
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    settle();

    // phase forced to zero
    set_phase_enable(1'b0);
    queue_sample(0, 0);
    queue_sample(-5, 0);
    queue_sample(100, -100);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_random(300);
    settle();

    set_phase_enable(1'b1);
    queue_random(400);
    settle();

    if (errors == 0 && polar_expected.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rtp_pkg.sv
hw/rtl/rtp_cordic.sv
hw/rtl/rtp_post.sv
hw/rtl/rect_to_polar_converter_core.sv
sim/tb.sv
